// ----- rtl/fcast_pkg.sv -----
// ----------------------------------------------------------------------------
// fcast_pkg
// Types, register codes and helpers shared by the floor casting texcoord
// generator.
// ----------------------------------------------------------------------------
`default_nettype none

package fcast_pkg;

	// One input item: a screen pixel.
	typedef struct packed {
		logic [11:0] row;
		logic        new_row;
	} fcast_in_t;

	// One result item.
	typedef struct packed {
		logic               valid_res;
		logic signed [15:0] cell_x;
		logic signed [15:0] cell_y;
		logic [9:0]         tex_x;
		logic [9:0]         tex_y;
		logic               tile_select;
	} fcast_out_t;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_X      = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Y      = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_DIR_X    = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_DIR_Y    = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CAM_PLANE_X   = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CAM_PLANE_Y   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 4'd7;

	// Divisor width: twice the largest row offset, or the screen width.
	localparam int DIV_VW = 13;

	typedef enum logic [1:0] {
		MUL_PLANE_X,
		MUL_PLANE_Y,
		MUL_WORLD_X,
		MUL_WORLD_Y
	} fcast_mul_sel_t;

	typedef enum logic {
		DIV_ROW_DIST,
		DIV_STEP
	} fcast_div_src_t;

	typedef struct packed {
		logic           cap_in;
		logic           div_start;
		fcast_div_src_t div_src;
		logic           ld_row_dist;
		logic           ld_step_x;
		logic           ld_step_y;
		logic           mul_en;
		fcast_mul_sel_t mul_sel;
		logic           ld_world_x;
		logic           ld_world_y;
		logic           set_row_ok;
		logic           clr_row_ok;
		logic           emit;
	} fcast_cmd_t;

	typedef struct packed {
		logic p_pos;
		logic div_busy;
		logic div_done;
		logic out_free;
	} fcast_sts_t;

	// Saturate a wide signed value to the signed 32-bit range.
	function automatic logic [31:0] sat32(input logic [65:0] v);
		logic [31:0] r;
		if (v[65:31] == '0 || v[65:31] == '1) begin
			r = v[31:0];
		end else if (v[65]) begin
			r = 32'h8000_0000;
		end else begin
			r = 32'h7FFF_FFFF;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/fcast_div.sv -----
// ----------------------------------------------------------------------------
// fcast_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fcast_div #(
	parameter int DW = 49,
	parameter int VW = 13
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	output logic               busy,
	output logic               done,
	output logic [DW-1:0]      quot,
	output logic [VW-1:0]      rem
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] quot_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [VW:0]   trial;
	logic [VW:0]   diff;
	logic          ge;

	assign trial = {rem_q, quot_q[DW-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift in one dividend bit, subtract when it fits
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[DW-2:0], ge};
			rem_q  <= ge ? diff[VW-1:0] : trial[VW-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a running division");

endmodule

`default_nettype wire

// ----- rtl/fcast_dp.sv -----
// ----------------------------------------------------------------------------
// fcast_dp
// Datapath: configuration, row setup arithmetic, world point and result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module fcast_dp #(
	parameter int TEX_SIZE  = 64,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	input  wire logic [fcast_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                     cfg_data,
	input  wire fcast_pkg::fcast_in_t            in_data,
	input  wire fcast_pkg::fcast_cmd_t           cmd,
	output fcast_pkg::fcast_sts_t                sts,
	input  wire logic                            out_stall,
	output logic                                 out_valid,
	output fcast_pkg::fcast_out_t                out_data
);

	import fcast_pkg::*;

	localparam int DIV_W   = (12 + FRAC_BITS > 65 - FRAC_BITS) ? 12 + FRAC_BITS
	                                                           : 65 - FRAC_BITS;
	localparam int TM_W    = 11 + FRAC_BITS;
	localparam logic [10:0] TEX_C    = 11'(TEX_SIZE);
	localparam logic [9:0]  TEX_MASK = 10'(TEX_SIZE - 1);

	// configuration
	logic signed [31:0] cam_x_q, cam_y_q, dir_x_q, dir_y_q, pln_x_q, pln_y_q;
	logic [11:0]        scr_w_q, scr_h_q;

	// row state
	logic [11:0]        row_q;
	logic signed [31:0] row_dist_q, step_x_q, step_y_q, world_x_q, world_y_q;
	logic               row_ok_q;
	logic signed [64:0] prod_q;
	logic               div_neg_q;

	fcast_out_t         out_q;
	logic               out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q <= '0;
			cam_y_q <= '0;
			dir_x_q <= -32'sd65536;
			dir_y_q <= '0;
			pln_x_q <= '0;
			pln_y_q <= 32'sd43253;
			scr_w_q <= 12'd640;
			scr_h_q <= 12'd480;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CAMERA_X:      cam_x_q <= cfg_data;
				CFG_CAMERA_Y:      cam_y_q <= cfg_data;
				CFG_VIEW_DIR_X:    dir_x_q <= cfg_data;
				CFG_VIEW_DIR_Y:    dir_y_q <= cfg_data;
				CFG_CAM_PLANE_X:   pln_x_q <= cfg_data;
				CFG_CAM_PLANE_Y:   pln_y_q <= cfg_data;
				CFG_SCREEN_WIDTH:  scr_w_q <= cfg_data[11:0];
				CFG_SCREEN_HEIGHT: scr_h_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// row offset below the horizon
	logic signed [12:0] p_off;
	logic               p_pos;
	assign p_off = signed'({1'b0, row_q}) - signed'({2'b00, scr_h_q[11:1]});
	assign p_pos = !p_off[12] && (p_off != '0);

	// divider operands
	logic signed [64:0] prod_shr;
	logic [64:0]        prod_mag;
	logic [DIV_W-1:0]   div_dividend;
	logic [DIV_VW-1:0]  div_divisor;
	logic [DIV_VW-1:0]  w_eff;
	logic [DIV_W-1:0]   div_quot;
	logic [DIV_VW-1:0]  div_rem;
	logic               div_busy, div_done;

	assign prod_shr = prod_q >>> (FRAC_BITS - 1);
	assign prod_mag = prod_q[64] ? 65'(-prod_shr) : 65'(prod_shr);
	assign w_eff    = (scr_w_q == '0) ? DIV_VW'(1) : DIV_VW'(scr_w_q);

	always_comb begin
		case (cmd.div_src)
			DIV_ROW_DIST: begin
				div_dividend = DIV_W'(scr_h_q) << FRAC_BITS;
				div_divisor  = {p_off[11:0], 1'b0};
			end
			DIV_STEP: begin
				div_dividend = prod_mag[DIV_W-1:0];
				div_divisor  = w_eff;
			end
			default: begin
				div_dividend = '0;
				div_divisor  = w_eff;
			end
		endcase
	end

	fcast_div #(
		.DW(DIV_W),
		.VW(DIV_VW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.busy    (div_busy),
		.done    (div_done),
		.quot    (div_quot),
		.rem     (div_rem)
	);

	// floor-correct and saturate the unsigned quotient
	logic [DIV_W:0] q_up;
	logic [31:0]    div_res;
	assign q_up = (DIV_W + 1)'(div_quot) + (DIV_W + 1)'(|div_rem);

	always_comb begin
		if (!div_neg_q) begin
			div_res = (div_quot > DIV_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
			                                            : div_quot[31:0];
		end else if (q_up > (DIV_W + 1)'(33'h0_8000_0000)) begin
			div_res = 32'h8000_0000;
		end else begin
			div_res = 32'(-q_up[31:0]);
		end
	end

	// multiplier operand
	logic signed [32:0] mul_b;
	always_comb begin
		case (cmd.mul_sel)
			MUL_PLANE_X: mul_b = {pln_x_q[31], pln_x_q};
			MUL_PLANE_Y: mul_b = {pln_y_q[31], pln_y_q};
			MUL_WORLD_X: mul_b = {dir_x_q[31], dir_x_q} - {pln_x_q[31], pln_x_q};
			MUL_WORLD_Y: mul_b = {dir_y_q[31], dir_y_q} - {pln_y_q[31], pln_y_q};
			default:     mul_b = '0;
		endcase
	end

	// start point: camera plus floored product
	logic signed [64:0] prod_frac;
	logic [31:0]        world_x_st, world_y_st;
	assign prod_frac  = prod_q >>> FRAC_BITS;
	assign world_x_st = sat32({{34{cam_x_q[31]}}, cam_x_q} + {prod_frac[64], prod_frac});
	assign world_y_st = sat32({{34{cam_y_q[31]}}, cam_y_q} + {prod_frac[64], prod_frac});

	// advanced point
	logic [31:0] world_x_nx, world_y_nx;
	assign world_x_nx = sat32({{34{world_x_q[31]}}, world_x_q}
	                        + {{34{step_x_q[31]}}, step_x_q});
	assign world_y_nx = sat32({{34{world_y_q[31]}}, world_y_q}
	                        + {{34{step_y_q[31]}}, step_y_q});

	// per-pixel result
	logic [47:0]     wx_ext, wy_ext;
	logic [TM_W-1:0] tmul_x, tmul_y;
	fcast_out_t      res;

	assign wx_ext = {{16{world_x_q[31]}}, world_x_q};
	assign wy_ext = {{16{world_y_q[31]}}, world_y_q};
	assign tmul_x = TM_W'(TEX_C) * TM_W'(world_x_q[FRAC_BITS-1:0]);
	assign tmul_y = TM_W'(TEX_C) * TM_W'(world_y_q[FRAC_BITS-1:0]);

	always_comb begin
		res = '0;
		if (row_ok_q) begin
			res.valid_res   = 1'b1;
			res.cell_x      = wx_ext[FRAC_BITS+15:FRAC_BITS];
			res.cell_y      = wy_ext[FRAC_BITS+15:FRAC_BITS];
			res.tex_x       = tmul_x[FRAC_BITS+9:FRAC_BITS] & TEX_MASK;
			res.tex_y       = tmul_y[FRAC_BITS+9:FRAC_BITS] & TEX_MASK;
			res.tile_select = world_x_q[FRAC_BITS] ^ world_y_q[FRAC_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_dist_q  <= '0;
			step_x_q    <= '0;
			step_y_q    <= '0;
			world_x_q   <= '0;
			world_y_q   <= '0;
			row_ok_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ld_row_dist) row_dist_q <= div_res;
			if (cmd.ld_step_x)   step_x_q   <= div_res;
			if (cmd.ld_step_y)   step_y_q   <= div_res;
			if (cmd.set_row_ok)  row_ok_q   <= 1'b1;
			if (cmd.clr_row_ok)  row_ok_q   <= 1'b0;
			if (cmd.ld_world_x)  world_x_q  <= world_x_st;
			if (cmd.ld_world_y)  world_y_q  <= world_y_st;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				if (row_ok_q) begin
					world_x_q <= world_x_nx;
					world_y_q <= world_y_nx;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_in) row_q <= in_data.row;
		if (cmd.mul_en) prod_q <= row_dist_q * mul_b;
		if (cmd.div_start) div_neg_q <= (cmd.div_src == DIV_STEP) && prod_q[64];
		if (cmd.emit) out_q <= res;
	end

	assign sts.p_pos    = p_pos;
	assign sts.div_busy = div_busy;
	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.valid_res) |-> (out_q.cell_x == '0 && out_q.cell_y == '0
			&& out_q.tex_x == '0 && out_q.tex_y == '0 && !out_q.tile_select))
		else $error("invalid result carries nonzero fields");

endmodule

`default_nettype wire

// ----- rtl/fcast_ctrl.sv -----
// ----------------------------------------------------------------------------
// fcast_ctrl
// Sequencer for row setup and pixel emission.
// ----------------------------------------------------------------------------
`default_nettype none

module fcast_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  new_row,
	output logic                       in_stall,
	input  wire fcast_pkg::fcast_sts_t sts,
	output fcast_pkg::fcast_cmd_t      cmd
);

	import fcast_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK,
		S_WAIT_RD,
		S_MUL_SX,
		S_START_SX,
		S_WAIT_SX,
		S_MUL_SY,
		S_START_SY,
		S_WAIT_SY,
		S_MUL_WX,
		S_LD_WX,
		S_MUL_WY,
		S_LD_WY,
		S_PIX
	} state_t;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		cmd.div_src = DIV_STEP;
		cmd.mul_sel = MUL_PLANE_X;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap_in = 1'b1;
					state_nx   = new_row ? S_CHK : S_PIX;
				end
			end
			S_CHK: begin
				cmd.div_src = DIV_ROW_DIST;
				if (sts.p_pos) begin
					cmd.div_start = 1'b1;
					state_nx      = S_WAIT_RD;
				end else begin
					cmd.clr_row_ok = 1'b1;
					state_nx       = S_PIX;
				end
			end
			S_WAIT_RD: begin
				if (sts.div_done) begin
					cmd.ld_row_dist = 1'b1;
					state_nx        = S_MUL_SX;
				end
			end
			S_MUL_SX: begin
				cmd.mul_en = 1'b1;
				state_nx   = S_START_SX;
			end
			S_START_SX: begin
				cmd.div_start = 1'b1;
				state_nx      = S_WAIT_SX;
			end
			S_WAIT_SX: begin
				if (sts.div_done) begin
					cmd.ld_step_x = 1'b1;
					state_nx      = S_MUL_SY;
				end
			end
			S_MUL_SY: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_PLANE_Y;
				state_nx    = S_START_SY;
			end
			S_START_SY: begin
				cmd.div_start = 1'b1;
				state_nx      = S_WAIT_SY;
			end
			S_WAIT_SY: begin
				if (sts.div_done) begin
					cmd.ld_step_y = 1'b1;
					state_nx      = S_MUL_WX;
				end
			end
			S_MUL_WX: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_WORLD_X;
				state_nx    = S_LD_WX;
			end
			S_LD_WX: begin
				cmd.ld_world_x = 1'b1;
				state_nx       = S_MUL_WY;
			end
			S_MUL_WY: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_WORLD_Y;
				state_nx    = S_LD_WY;
			end
			S_LD_WY: begin
				cmd.ld_world_y = 1'b1;
				cmd.set_row_ok = 1'b1;
				state_nx       = S_PIX;
			end
			S_PIX: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result loaded over an untaken result");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("division started while divider busy");

	a_take_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cap_in |=> (state_q == S_CHK || state_q == S_PIX))
		else $error("accepted pixel not routed to setup or emission");

endmodule

`default_nettype wire

// ----- rtl/floor_cast_texcoord_gen.sv -----
// ----------------------------------------------------------------------------
// floor_cast_texcoord_gen
// Perspective floor casting: floor cell, texel and checker tile per pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one pixel per
//   transfer; set new_row on the first pixel of each screen row so the block
//   recomputes row distance, per-pixel step and start point for that row.
//   Output channel (out_valid / out_stall / out_data) returns one result per
//   pixel, in order. Rows at or above the horizon return valid_res = 0 with
//   all other fields zero.
//   Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data)
//   writes camera, direction, plane (signed Q16.16) and screen size; write
//   only while no pixel is in flight. cfg_ready is always high.
// Sequence:
//   A pixel without row setup passes from the idle state, which takes it, to
//   the emission step, which loads its result into the output register. A row
//   setup pixel below the horizon adds three passes through the shared
//   bit-serial divider (one quotient bit per cycle, 12 + FRAC_BITS or
//   65 - FRAC_BITS bits, whichever is larger) plus the multiply and load steps.
//   One pixel is in work at a time; in_stall stays high until its result
//   sits in the output register.
// Reset: clears the row state (every pixel reads invalid until a row setup)
//   and loads the register defaults. A stalled output holds its result and
//   the next pixel waits in its emission step until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module floor_cast_texcoord_gen #(
	parameter int TEX_SIZE  = 64,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// pixel input
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire fcast_pkg::fcast_in_t            in_data,
	// result output
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output fcast_pkg::fcast_out_t                out_data,
	// configuration writes
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [fcast_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                     cfg_data
);

	import fcast_pkg::*;

	fcast_cmd_t cmd;
	fcast_sts_t sts;

	// Registers accept every write; the user keeps writes to idle periods.
	assign cfg_ready = 1'b1;

	// Sequencer: accept a pixel, run row setup if flagged, emit the result.
	fcast_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.new_row (in_data.new_row),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	// Datapath: registers, shared multiplier and divider, result register.
	fcast_dp #(
		.TEX_SIZE (TEX_SIZE),
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_data (out_data)
	);

endmodule

`default_nettype wire

// ----- dv/fcast_texcoord_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcast_texcoord_checker
// Watches the pixel, result and register channels of the floor casting
// generator, predicts every result from its own copy of the camera setup and
// row state, and compares each result transfer field by field.
// ----------------------------------------------------------------------------

module fcast_texcoord_checker #(
	parameter int TEX_SIZE  = 64,
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  fcast_pkg::fcast_in_t            in_data,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  fcast_pkg::fcast_out_t           out_data,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [fcast_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                     cfg_data,
	output int                              mismatches,
	output int                              pending
);

	localparam longint ONE     = 64'sd1 << FRAC_BITS;
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	// camera setup
	logic signed [31:0] cam_x, cam_y, dir_x, dir_y, plane_x, plane_y;
	logic [11:0]        scr_w, scr_h;

	// row state
	logic signed [31:0] row_dist, stp_x, stp_y, pos_x, pos_y;
	logic               below_horizon;

	fcast_pkg::fcast_out_t texcoord_q[$];

	initial begin
		mismatches = 0;
		pending    = 0;
	end

	function automatic longint floor_div(longint a, longint d);
		longint q;
		q = a / d;
		if ((a % d) != 0 && a < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > S32_MAX)
			return 32'sh7FFF_FFFF;
		if (v < S32_MIN)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic [9:0] texel_of(logic signed [31:0] pos);
		longint t;
		t = longint'(pos) & (ONE - 1);
		t = ((TEX_SIZE * t) >> FRAC_BITS) & (TEX_SIZE - 1);
		return t[9:0];
	endfunction

	task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
		$display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
		mismatches++;
	endtask

	// Row setup: distance to the floor line, per-pixel step and leftmost point.
	task automatic start_row(input logic [11:0] r);
		longint half, p, w, sdiv;
		half = longint'(scr_h >> 1);
		p    = longint'(r) - half;
		w    = (scr_w == '0) ? 64'sd1 : longint'(scr_w);
		sdiv = w << (FRAC_BITS - 1);
		if (p <= 0) begin
			below_horizon = 1'b0;
		end else begin
			below_horizon = 1'b1;
			row_dist = clamp32(floor_div(longint'(scr_h) * ONE, 2 * p));
			stp_x = clamp32(floor_div(longint'(row_dist) * longint'(plane_x), sdiv));
			stp_y = clamp32(floor_div(longint'(row_dist) * longint'(plane_y), sdiv));
			pos_x = clamp32(longint'(cam_x) +
				floor_div(longint'(row_dist) * (longint'(dir_x) - longint'(plane_x)), ONE));
			pos_y = clamp32(longint'(cam_y) +
				floor_div(longint'(row_dist) * (longint'(dir_y) - longint'(plane_y)), ONE));
		end
	endtask

	task automatic advance_pixel(input fcast_pkg::fcast_in_t px,
			output fcast_pkg::fcast_out_t res);
		logic signed [31:0] cx, cy;
		if (px.new_row)
			start_row(px.row);
		res = '0;
		if (below_horizon) begin
			cx = pos_x >>> FRAC_BITS;
			cy = pos_y >>> FRAC_BITS;
			res.valid_res   = 1'b1;
			res.cell_x      = cx[15:0];
			res.cell_y      = cy[15:0];
			res.tex_x       = texel_of(pos_x);
			res.tex_y       = texel_of(pos_y);
			res.tile_select = cx[0] ^ cy[0];
			pos_x = clamp32(longint'(pos_x) + longint'(stp_x));
			pos_y = clamp32(longint'(pos_y) + longint'(stp_y));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		fcast_pkg::fcast_out_t want;
		if (!arst_n) begin
			cam_x = '0; cam_y = '0;
			dir_x = -32'sd65536; dir_y = '0;
			plane_x = '0; plane_y = 32'sd43253;
			scr_w = 12'd640; scr_h = 12'd480;
			row_dist = '0; stp_x = '0; stp_y = '0; pos_x = '0; pos_y = '0;
			below_horizon = 1'b0;
			texcoord_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					fcast_pkg::CFG_CAMERA_X:      cam_x   = cfg_data;
					fcast_pkg::CFG_CAMERA_Y:      cam_y   = cfg_data;
					fcast_pkg::CFG_VIEW_DIR_X:    dir_x   = cfg_data;
					fcast_pkg::CFG_VIEW_DIR_Y:    dir_y   = cfg_data;
					fcast_pkg::CFG_CAM_PLANE_X:   plane_x = cfg_data;
					fcast_pkg::CFG_CAM_PLANE_Y:   plane_y = cfg_data;
					fcast_pkg::CFG_SCREEN_WIDTH:  scr_w   = cfg_data[11:0];
					fcast_pkg::CFG_SCREEN_HEIGHT: scr_h   = cfg_data[11:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				advance_pixel(in_data, want);
				texcoord_q.push_back(want);
			end
			if (out_valid && !out_stall) begin
				if (texcoord_q.size() == 0) begin
					report("unexpected result", '0, 64'(out_data));
				end else begin
					want = texcoord_q.pop_front();
					if (out_data.valid_res !== want.valid_res)
						report("valid_res", 64'(want.valid_res), 64'(out_data.valid_res));
					if (out_data.cell_x !== want.cell_x)
						report("cell_x", 64'(want.cell_x), 64'(out_data.cell_x));
					if (out_data.cell_y !== want.cell_y)
						report("cell_y", 64'(want.cell_y), 64'(out_data.cell_y));
					if (out_data.tex_x !== want.tex_x)
						report("tex_x", 64'(want.tex_x), 64'(out_data.tex_x));
					if (out_data.tex_y !== want.tex_y)
						report("tex_y", 64'(want.tex_y), 64'(out_data.tex_y));
					if (out_data.tile_select !== want.tile_select)
						report("tile_select", 64'(want.tile_select),
							64'(out_data.tile_select));
				end
			end
			pending = texcoord_q.size();
		end
	end

endmodule

// ----- dv/tb_floor_cast_texcoord_gen.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_floor_cast_texcoord_gen
// Drives pixels and camera setups into the floor casting generator: a
// directed pass over the horizon, saturation and degenerate screen cases,
// then randomized rows under several camera setups with random idling on
// both channels and one long output hold-off. Checking lives in the checker.
// ----------------------------------------------------------------------------

module tb_floor_cast_texcoord_gen;

	import fcast_pkg::*;

	// An index that decodes to no register; writes to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 4'd15;

	// Longest stretch without any transfer before the run is declared hung.
	// Covers the output hold-off, a full row setup and random stalls.
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_OFF       = 400;
	localparam int HOLD_AT        = 60;
	localparam int PHASE_PIXELS   = 80;

	typedef enum {VIEW_PLAIN, VIEW_WILD, VIEW_TINY} view_kind_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	fcast_in_t            in_data   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	fcast_out_t           out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data  = '0;

	int         mismatches;
	int         pending;
	int         quiet_cycles = 0;
	bit         idle_on      = 1'b1;
	logic [11:0] cur_height  = 12'd480;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	floor_cast_texcoord_gen dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	fcast_texcoord_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// Hang detection: count edges at which no channel moves a transfer.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold-off once a number of
	// results have gone through, so the block backs up into its input.
	initial begin
		int  taken;
		int  hold_left;
		bit  held;
		taken     = 0;
		hold_left = 0;
		held      = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				taken++;
			if (!held && taken >= HOLD_AT) begin
				held      = 1'b1;
				hold_left = HOLD_OFF;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= idle_on && ($urandom_range(99) < 22);
			end
		end
	end

	// Offer one pixel, idling first at random; return at the edge that takes
	// it. Valid stays high afterwards: the next call or a drain drops it.
	task automatic send_pixel(input logic [11:0] r, input logic nr);
		while (idle_on && $urandom_range(99) < 22) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{row: r, new_row: nr};
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid and hold until every pixel sent has come back, then a few
	// more edges so the block is surely idle.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Write the whole camera setup; only call with the block drained.
	task automatic load_view(input logic [31:0] cx, cy, dx, dy, px, py,
			input logic [11:0] w, h, input bit poke_spare);
		write_reg(CFG_CAMERA_X, cx);
		write_reg(CFG_CAMERA_Y, cy);
		write_reg(CFG_VIEW_DIR_X, dx);
		write_reg(CFG_VIEW_DIR_Y, dy);
		write_reg(CFG_CAM_PLANE_X, px);
		write_reg(CFG_CAM_PLANE_Y, py);
		write_reg(CFG_SCREEN_WIDTH, {20'($urandom_range(1048575)), w});
		write_reg(CFG_SCREEN_HEIGHT, {20'($urandom_range(1048575)), h});
		if (poke_spare)
			write_reg(CFG_SPARE, $urandom());
		cfg_valid  <= 1'b0;
		cur_height  = h;
	endtask

	// Symmetric random value in [-span, span].
	function automatic logic [31:0] spread(input int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	task automatic random_view(input view_kind_t kind);
		case (kind)
			VIEW_WILD: begin
				load_view($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
					$urandom(), 12'($urandom_range(4095)), 12'($urandom_range(4095)),
					1'b0);
			end
			VIEW_TINY: begin
				load_view(spread(1 << 20), spread(1 << 20), spread(65536), spread(65536),
					spread(65536), spread(65536), 12'($urandom_range(3)),
					12'($urandom_range(8)), 1'b0);
			end
			default: begin
				load_view(spread(1 << 22), spread(1 << 22), spread(65536), spread(65536),
					spread(65536), spread(65536), 12'($urandom_range(1, 4095)),
					12'($urandom_range(2, 1024)), 1'b0);
			end
		endcase
	endtask

	// Mostly rows below the horizon of the current screen; now and then any row.
	function automatic logic [11:0] pick_row();
		int half;
		if ($urandom_range(9) == 0 || cur_height < 2)
			return 12'($urandom_range(4095));
		half = int'(cur_height >> 1);
		return 12'(half + 1 + int'($urandom_range(int'(cur_height) - half - 1)));
	endfunction

	initial begin
		int ph;
		int sent;
		int len;
		view_kind_t kind;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setup: pixel before any row, horizon and above, nearest row,
		// last screen row and a row beyond the screen.
		send_pixel(12'd0, 1'b0);
		send_pixel(12'd240, 1'b1);
		send_pixel(12'd0, 1'b1);
		send_pixel(12'd241, 1'b1);
		send_pixel(12'd4095, 1'b0);
		send_pixel(12'd479, 1'b1);
		send_pixel(12'd0, 1'b0);
		send_pixel(12'd0, 1'b0);
		send_pixel(12'd4095, 1'b1);
		send_pixel(12'd300, 1'b1);
		send_pixel(12'hAAA, 1'b0);

		// Extreme camera and a one-pixel-wide, full-height screen: saturate
		// the distance products, the start point and the stepping.
		drain();
		load_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 32'h7FFF_FFFF, 12'd1, 12'd4095, 1'b0);
		send_pixel(12'd2047, 1'b1);
		send_pixel(12'd2048, 1'b1);
		send_pixel(12'h555, 1'b0);
		send_pixel(12'd0, 1'b0);
		send_pixel(12'd4095, 1'b1);
		send_pixel(12'd0, 1'b0);

		// Zero width and zero height: horizon at row 0, distance collapses.
		drain();
		load_view(32'h0001_8000, 32'hFFFF_4000, 32'h0001_0000, 32'h0000_0000,
			32'h0000_0000, 32'h0000_A8F5, 12'd0, 12'd0, 1'b0);
		send_pixel(12'd0, 1'b1);
		send_pixel(12'd1, 1'b1);
		send_pixel(12'd0, 1'b0);

		// Height one, widest screen, negative directions; also hit a spare index.
		drain();
		load_view(32'hFFF0_0000, 32'h0010_0000, 32'h0000_0000, 32'hFFFF_0000,
			32'hFFFF_5555, 32'h0000_0000, 12'd4095, 12'd1, 1'b1);
		send_pixel(12'd1, 1'b1);
		send_pixel(12'd4095, 1'b1);
		send_pixel(12'd0, 1'b0);

		// Random part: each phase gets a fresh camera, then rows that start
		// with a setup pixel and run a random number of pixels along.
		for (ph = 0; ph < 5; ph++) begin
			drain();
			kind = (ph == 2) ? VIEW_WILD : (ph == 4) ? VIEW_TINY : VIEW_PLAIN;
			random_view(kind);
			// keep one whole phase free of idling on both sides
			idle_on = (ph != 1);
			sent = 0;
			while (sent < PHASE_PIXELS) begin
				send_pixel(pick_row(), 1'b1);
				sent++;
				len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(12);
				repeat (len) begin
					send_pixel(12'($urandom_range(4095)), 1'b0);
					sent++;
				end
			end
		end
		idle_on = 1'b1;

		// Let the last results come out, then allow for a full setup time.
		drain();
		repeat (200) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
